>>> rtl/core/spq_pkg.sv
// shared types and codes for the sorted priority queue
package spq_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_ZERO_PRIO = 2'd3
    } status_t;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    typedef struct packed {
        logic               func;
        logic signed [31:0] key;
        logic signed [15:0] priority_req;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_key;
        logic signed [15:0] out_priority;
        logic [4:0]         fill_count;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [15:0] prio;
    } entry_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic rd_prev;
        logic rd_head;
        logic write_shift;
        logic write_new;
        logic pop_commit;
        logic rsp_load;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic req_ok;
        logic req_pop;
        logic full;
        logic empty;
        logic i_zero;
        logic rd_greater;
    } stat_t;

endpackage

>>> rtl/core/spq_dp.sv
// datapath: circular entry store, head/tail pointers, insertion walk and result register
module spq_dp #(
    parameter int CAPACITY = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  spq_pkg::req_t  req,
    input  spq_pkg::cmd_t  cmd,
    output spq_pkg::stat_t stat,
    output spq_pkg::rsp_t  rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    spq_pkg::entry_t mem [CAPACITY];

    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      p_reg, p_next;
    logic [CW-1:0]      i_reg, i_next;
    logic signed [31:0] item_key_reg, item_key_next;
    logic signed [15:0] item_prio_reg, item_prio_next;
    logic [1:0]         status_reg, status_next;
    logic signed [31:0] res_key_reg, res_key_next;
    logic signed [15:0] res_prio_reg, res_prio_next;
    spq_pkg::entry_t    rd_data_reg;
    spq_pkg::rsp_t      rsp_reg, rsp_next;

    logic [AW-1:0]      p_prev;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;
    logic               wr_en;
    spq_pkg::entry_t    wr_data;
    logic               zero_prio;
    logic               req_pop;

    assign p_prev    = (p_reg == '0) ? AW'(CAPACITY - 1) : p_reg - AW'(1);
    assign zero_prio = (req.priority_req == 16'sd0);
    assign req_pop   = (req.func == spq_pkg::FUNC_POP);

    always_comb
    begin
        stat.req_pop    = req_pop;
        stat.full       = (count_reg == CW'(CAPACITY));
        stat.empty      = (count_reg == '0);
        stat.req_ok     = req_pop ? !stat.empty : (!zero_prio && !stat.full);
        stat.i_zero     = (i_reg == '0);
        stat.rd_greater = (rd_data_reg.prio > item_prio_reg);
    end

    assign rd_en   = cmd.rd_prev | cmd.rd_head;
    assign rd_addr = cmd.rd_head ? head_reg : p_prev;
    assign wr_en   = cmd.write_shift | cmd.write_new;
    assign wr_data = cmd.write_shift ? rd_data_reg
                                     : spq_pkg::entry_t'{key: item_key_reg, prio: item_prio_reg};

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        p_next         = p_reg;
        i_next         = i_reg;
        item_key_next  = item_key_reg;
        item_prio_next = item_prio_reg;
        status_next    = status_reg;
        res_key_next   = res_key_reg;
        res_prio_next  = res_prio_reg;
        rsp_next       = rsp_reg;

        if (cmd.load_item)
        begin
            item_key_next  = req.key;
            item_prio_next = req.priority_req;
            p_next         = tail_reg;
            i_next         = count_reg;
            res_key_next   = '0;
            res_prio_next  = '0;
            if (req_pop)
                status_next = stat.empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
            else if (zero_prio)
                status_next = spq_pkg::ST_ZERO_PRIO;
            else if (stat.full)
                status_next = spq_pkg::ST_FULL;
            else
                status_next = spq_pkg::ST_OK;
        end

        // entry moves one place towards the tail
        if (cmd.write_shift)
        begin
            p_next = p_prev;
            i_next = i_reg - CW'(1);
        end

        if (cmd.write_new)
        begin
            count_next = count_reg + CW'(1);
            tail_next  = (tail_reg == AW'(CAPACITY - 1)) ? '0 : tail_reg + AW'(1);
        end

        if (cmd.pop_commit)
        begin
            res_key_next  = rd_data_reg.key;
            res_prio_next = rd_data_reg.prio;
            count_next    = count_reg - CW'(1);
            head_next     = (head_reg == AW'(CAPACITY - 1)) ? '0 : head_reg + AW'(1);
        end

        if (cmd.rsp_load)
        begin
            rsp_next.status       = status_reg;
            rsp_next.out_key      = res_key_reg;
            rsp_next.out_priority = res_prio_reg;
            rsp_next.fill_count   = 5'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        i_reg         <= i_next;
        item_key_reg  <= item_key_next;
        item_prio_reg <= item_prio_next;
        status_reg    <= status_next;
        res_key_reg   <= res_key_next;
        res_prio_reg  <= res_prio_next;
        rsp_reg       <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[p_reg] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rsp = rsp_reg;

endmodule

>>> rtl/core/spq_ctrl.sv
// controller: sequences push walks, pops and the result hand-off
module spq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    input  spq_pkg::stat_t stat,
    output spq_pkg::cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_SHIFT_CHK = 6'b000010,
        S_SHIFT_CMP = 6'b000100,
        S_POP_RD    = 6'b001000,
        S_POP_CAP   = 6'b010000,
        S_FINISH    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (!stat.req_ok)
                        state_next = S_FINISH;
                    else if (stat.req_pop)
                        state_next = S_POP_RD;
                    else
                        state_next = S_SHIFT_CHK;
                end
            end
            S_SHIFT_CHK:
            begin
                if (stat.i_zero)
                begin
                    cmd.write_new = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_SHIFT_CMP;
                end
            end
            S_SHIFT_CMP:
            begin
                // strictly greater moves back, so equal priorities keep arrival order
                if (stat.rd_greater)
                begin
                    cmd.write_shift = 1'b1;
                    state_next      = S_SHIFT_CHK;
                end
                else
                begin
                    cmd.write_new = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_POP_RD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = S_POP_CAP;
            end
            S_POP_CAP:
            begin
                cmd.pop_commit = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.rsp_load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

>>> rtl/core/sorted_priority_queue.sv
// Sorted priority queue holding up to CAPACITY (key, priority) entries in a single-port
// circular store; lower priority leaves first and equal priorities leave in arrival order.
// One request beat gives exactly one response beat. A rejected request (zero priority,
// push when full, pop when empty) goes straight to the result; a pop steps through head
// read, capture and result; a push walks the insertion over every held entry with a
// strictly greater priority, moving one entry per read/write pair of the store, and ends
// with a stopping compare unless the new entry goes in at the head. A finished result sits
// in an output register so the next request can be taken while it waits. The store needs
// no clearing after reset.
module sorted_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  spq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output spq_pkg::rsp_t rsp
);

    spq_pkg::cmd_t  cmd;
    spq_pkg::stat_t stat;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while an item was in progress");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.full && stat.empty))
        else $error("queue reported full and empty together");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == spq_pkg::ST_FULL) |-> (rsp.fill_count == 5'(CAPACITY)))
        else $error("full status with a count below capacity");

    a_empty_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == spq_pkg::ST_EMPTY)
            |-> (rsp.fill_count == 5'd0 && rsp.out_key == 32'sd0 && rsp.out_priority == 16'sd0))
        else $error("empty status with a non-zero entry or count");
`endif

endmodule
